### rtl/core/mcr_pkg.sv
// Shared types, constants and codes for the memory card responder.
package mcr_pkg;

    localparam int SECTOR_BYTES = 128;
    localparam int SECTOR_COUNT = 1024;
    localparam int STORE_BYTES  = SECTOR_COUNT * SECTOR_BYTES;
    localparam int IDX_W        = $clog2(SECTOR_BYTES);
    localparam int SEC_W        = $clog2(SECTOR_COUNT);
    localparam int ADDR_W       = SEC_W + IDX_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [16:0] SECTOR_LIMIT = 17'(SECTOR_COUNT);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(SECTOR_BYTES - 1);

    localparam logic [7:0] CMD_START   = 8'h81;
    localparam logic [7:0] CMD_READ    = 8'h52;
    localparam logic [7:0] CMD_WRITE   = 8'h57;
    localparam logic [7:0] CMD_ID      = 8'h53;
    localparam logic [7:0] ID_TAIL_A   = 8'h04;
    localparam logic [7:0] ID_TAIL_B   = 8'h00;
    localparam logic [7:0] ID_TAIL_C   = 8'h00;
    localparam logic [7:0] ID_TAIL_D   = 8'h80;
    localparam logic [7:0] BAD_SECTOR  = 8'hff;
    localparam logic [7:0] FILLER      = 8'h00;
    localparam logic [7:0] FLAG_NEW    = 8'h08;
    localparam logic [7:0] FLAG_USED   = 8'h00;

    localparam logic [7:0] RST_ID_FIRST    = 8'h5a;
    localparam logic [7:0] RST_ID_SECOND   = 8'h5d;
    localparam logic [7:0] RST_ACK_FIRST   = 8'h5c;
    localparam logic [7:0] RST_ACK_SECOND  = 8'h5d;
    localparam logic [7:0] RST_STAT_GOOD   = 8'h47;
    localparam logic [7:0] RST_STAT_BADCHK = 8'h4e;
    localparam logic [7:0] RST_STAT_BADSEC = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID_FIRST,
        CFG_ID_SECOND,
        CFG_ACK_FIRST,
        CFG_ACK_SECOND,
        CFG_STATUS_GOOD,
        CFG_STATUS_BAD_CHECKSUM,
        CFG_STATUS_BAD_SECTOR
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_READ,
        KIND_WRITE,
        KIND_ID
    } cmd_kind_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_CMD, PH_FILL1, PH_FILL2,
        PH_R_MSB, PH_R_LSB, PH_R_F1, PH_R_F2, PH_R_CONF1, PH_R_CONF2,
        PH_R_DATA, PH_R_CHK, PH_R_END, PH_R_BAD1, PH_R_BAD2,
        PH_W_MSB, PH_W_LSB, PH_W_DATA, PH_W_CHK, PH_W_F1, PH_W_F2, PH_W_END,
        PH_ID1, PH_ID2, PH_ID3, PH_ID4, PH_ID5, PH_ID6
    } phase_t;

    typedef struct packed {
        logic       deselect;
        logic [7:0] host_byte;
    } mcr_in_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       acknowledge;
        logic       exchange_done;
    } mcr_out_t;

endpackage

### rtl/core/memory_card_responder_core.sv
// Memory card responder: card-side byte exchange engine over a sector store.
// Path: a result is registered in stage two and then in the output register.
// Throughput: one transaction per cycle unless a clearing pass runs or the output
// stalls; a store byte read at the accept edge is merged into the reply and checksum.
// Reset: config registers take their defaults, the exchange goes idle and a
// clearing pass zeroes all STORE_BYTES (131072) store entries with s_ready low.
module memory_card_responder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mcr_pkg::mcr_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mcr_pkg::mcr_out_t                   m_data,
    input  logic                                cfg_we,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mcr_pkg::*;

    // Configuration registers.
    logic [7:0] id_first_reg, id_second_reg, ack_first_reg, ack_second_reg;
    logic [7:0] stat_good_reg, stat_badchk_reg, stat_badsec_reg;

    // Exchange state.
    phase_t          phase_reg, phase_next;
    cmd_kind_t       kind_reg, kind_next;
    logic [7:0]      sec_hi_reg, sec_hi_next;
    logic [7:0]      sec_lo_reg, sec_lo_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]      chk_reg, chk_next;
    logic [7:0]      rchk_reg, rchk_next;
    logic            ffb_reg, ffb_next;
    logic [7:0]      flag_reg, flag_next;

    // Sector store and its clearing pass.
    logic [7:0]       card_mem [STORE_BYTES];
    logic [7:0]       rd_data_reg;
    logic             clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Stage two: result waiting for the store read data.
    logic       s2_valid_reg;
    logic       s2_mem_reg;
    logic [7:0] s2_reply_reg;
    logic       s2_ack_reg;
    logic       s2_done_reg;

    // Output register.
    logic       m_valid_reg;
    mcr_out_t   m_data_reg;

    // Per-transaction decode.
    logic [7:0]       b;
    logic             go_idle;
    logic [7:0]       reply_c;
    logic             done_c;
    logic             use_mem_c;
    logic             rd_en_c;
    logic [ADDR_W-1:0] rd_addr_c;
    logic             wr_en_c;
    logic [ADDR_W-1:0] wr_addr_c;
    logic [15:0]      sector_w;
    logic             sector_ok;
    logic [7:0]       eff_chk;
    logic [IDX_W-1:0] idx_inc;

    logic accept;
    logic out_free;
    logic s2_advance;
    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0] mem_wdata;

    assign b         = s_data.host_byte;
    assign sector_w  = {sec_hi_reg, sec_lo_reg};
    assign sector_ok = {1'b0, sector_w} < SECTOR_LIMIT;
    assign idx_inc   = idx_reg + IDX_W'(1);

    // Handshake: take a transaction whenever no clearing pass runs and stage two is empty or can move on.
    assign out_free   = !m_valid_reg || m_ready;
    assign s2_advance = s2_valid_reg && out_free;
    assign s_ready    = !clr_active_reg && (!s2_valid_reg || out_free);
    assign accept     = s_valid && s_ready;

    // Forward the pending sector byte into the checksum seen by this transaction.
    assign eff_chk = (s2_valid_reg && s2_mem_reg) ? (chk_reg ^ rd_data_reg) : chk_reg;

    // Next phase and the decision to drop back to idle.
    always_comb begin
        phase_next = phase_reg;
        go_idle    = 1'b0;
        if (s_data.deselect) begin
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (b == CMD_START) phase_next = PH_CMD;
                    else go_idle = 1'b1;
                end
                PH_CMD:   phase_next = PH_FILL1;
                PH_FILL1: phase_next = PH_FILL2;
                PH_FILL2: begin
                    priority if (ffb_reg || b != FILLER || kind_reg == KIND_NONE) begin
                        go_idle = 1'b1;
                    end else if (kind_reg == KIND_READ) begin
                        phase_next = PH_R_MSB;
                    end else if (kind_reg == KIND_WRITE) begin
                        phase_next = PH_W_MSB;
                    end else begin
                        phase_next = PH_ID1;
                    end
                end
                PH_R_MSB: phase_next = PH_R_LSB;
                PH_R_LSB: phase_next = PH_R_F1;
                PH_R_F1: begin
                    if (b != FILLER) go_idle = 1'b1;
                    else phase_next = PH_R_F2;
                end
                PH_R_F2: begin
                    priority if (b != FILLER) go_idle = 1'b1;
                    else if (sector_ok) phase_next = PH_R_CONF1;
                    else phase_next = PH_R_BAD1;
                end
                PH_R_CONF1: begin
                    if (b != FILLER) go_idle = 1'b1;
                    else phase_next = PH_R_CONF2;
                end
                PH_R_CONF2: begin
                    if (b != FILLER) go_idle = 1'b1;
                    else phase_next = PH_R_DATA;
                end
                PH_R_DATA: begin
                    priority if (b != FILLER) go_idle = 1'b1;
                    else if (idx_reg == LAST_INDEX) phase_next = PH_R_CHK;
                    else phase_next = PH_R_DATA;
                end
                PH_R_CHK: begin
                    if (b != FILLER) go_idle = 1'b1;
                    else phase_next = PH_R_END;
                end
                PH_R_BAD1: phase_next = PH_R_BAD2;
                PH_W_MSB:  phase_next = PH_W_LSB;
                PH_W_LSB:  phase_next = PH_W_DATA;
                PH_W_DATA: begin
                    if (idx_reg == LAST_INDEX) phase_next = PH_W_CHK;
                end
                PH_W_CHK: phase_next = PH_W_F1;
                PH_W_F1, PH_W_F2, PH_ID1, PH_ID2, PH_ID3, PH_ID4, PH_ID5: begin
                    if (b != FILLER) go_idle = 1'b1;
                    else phase_next = phase_t'(phase_reg + 5'd1);
                end
                default: go_idle = 1'b1;
            endcase
            if (go_idle) phase_next = PH_IDLE;
        end
    end

    // Reply, store access and datapath register updates.
    always_comb begin
        reply_c     = 8'h00;
        done_c      = 1'b0;
        use_mem_c   = 1'b0;
        rd_en_c     = 1'b0;
        wr_en_c     = 1'b0;
        wr_addr_c   = {sector_w[SEC_W-1:0], idx_reg};
        kind_next   = kind_reg;
        sec_hi_next = sec_hi_reg;
        sec_lo_next = sec_lo_reg;
        idx_next    = idx_reg;
        chk_next    = eff_chk;
        rchk_next   = rchk_reg;
        ffb_next    = ffb_reg;
        flag_next   = flag_reg;
        rd_addr_c   = {sector_w[SEC_W-1:0], idx_reg};
        if (!s_data.deselect) begin
            unique case (phase_reg)
                PH_IDLE: reply_c = flag_reg;
                PH_CMD: begin
                    priority if (b == CMD_READ) kind_next = KIND_READ;
                    else if (b == CMD_WRITE) kind_next = KIND_WRITE;
                    else if (b == CMD_ID) kind_next = KIND_ID;
                    else kind_next = KIND_NONE;
                    reply_c = id_first_reg;
                end
                PH_FILL1: begin
                    ffb_next = (b != FILLER);
                    reply_c  = id_second_reg;
                end
                PH_FILL2: begin
                    reply_c = (kind_reg == KIND_ID) ? ack_first_reg : FILLER;
                end
                PH_R_MSB, PH_W_MSB: begin
                    sec_hi_next = b;
                    reply_c     = b;
                end
                PH_R_LSB: begin
                    sec_lo_next = b;
                    reply_c     = ack_first_reg;
                end
                PH_R_F1: reply_c = ack_second_reg;
                PH_R_F2: reply_c = sector_ok ? sec_hi_reg : BAD_SECTOR;
                PH_R_CONF1: begin
                    reply_c  = sec_lo_reg;
                    chk_next = sec_hi_reg ^ sec_lo_reg;
                end
                PH_R_CONF2: begin
                    // Sector byte zero is read from the store into the read data register.
                    idx_next  = '0;
                    rd_addr_c = {sector_w[SEC_W-1:0], {IDX_W{1'b0}}};
                    rd_en_c   = (b == FILLER);
                    use_mem_c = 1'b1;
                end
                PH_R_DATA: begin
                    if (idx_reg == LAST_INDEX) begin
                        reply_c = eff_chk;
                    end else begin
                        idx_next  = idx_inc;
                        rd_addr_c = {sector_w[SEC_W-1:0], idx_inc};
                        rd_en_c   = (b == FILLER);
                        use_mem_c = 1'b1;
                    end
                end
                PH_R_CHK:  reply_c = stat_good_reg;
                PH_R_END, PH_ID6: done_c = (b == FILLER);
                PH_R_BAD1: reply_c = BAD_SECTOR;
                PH_R_BAD2: reply_c = FILLER;
                PH_W_LSB: begin
                    sec_lo_next = b;
                    reply_c     = b;
                    chk_next    = sec_hi_reg ^ b;
                    idx_next    = '0;
                end
                PH_W_DATA: begin
                    reply_c  = b;
                    chk_next = eff_chk ^ b;
                    wr_en_c  = sector_ok;
                    if (idx_reg != LAST_INDEX) idx_next = idx_inc;
                end
                PH_W_CHK: begin
                    rchk_next = b;
                    reply_c   = ack_first_reg;
                end
                PH_W_F1: reply_c = ack_second_reg;
                PH_W_F2: begin
                    priority if (!sector_ok) reply_c = stat_badsec_reg;
                    else if (rchk_reg != eff_chk) reply_c = stat_badchk_reg;
                    else reply_c = stat_good_reg;
                end
                PH_W_END: begin
                    if (b == FILLER) begin
                        done_c    = 1'b1;
                        flag_next = FLAG_USED;
                    end
                end
                PH_ID1: reply_c = ack_second_reg;
                PH_ID2: reply_c = ID_TAIL_A;
                PH_ID3: reply_c = ID_TAIL_B;
                PH_ID4: reply_c = ID_TAIL_C;
                PH_ID5: reply_c = ID_TAIL_D;
                default: reply_c = FILLER;
            endcase
            // Drop the reply whenever the exchange ends or stays idle.
            if (go_idle) begin
                reply_c   = 8'h00;
                use_mem_c = 1'b0;
            end
        end
    end

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_first_reg    <= RST_ID_FIRST;
            id_second_reg   <= RST_ID_SECOND;
            ack_first_reg   <= RST_ACK_FIRST;
            ack_second_reg  <= RST_ACK_SECOND;
            stat_good_reg   <= RST_STAT_GOOD;
            stat_badchk_reg <= RST_STAT_BADCHK;
            stat_badsec_reg <= RST_STAT_BADSEC;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ID_FIRST:            id_first_reg    <= cfg_wdata;
                CFG_ID_SECOND:           id_second_reg   <= cfg_wdata;
                CFG_ACK_FIRST:           ack_first_reg   <= cfg_wdata;
                CFG_ACK_SECOND:          ack_second_reg  <= cfg_wdata;
                CFG_STATUS_GOOD:         stat_good_reg   <= cfg_wdata;
                CFG_STATUS_BAD_CHECKSUM: stat_badchk_reg <= cfg_wdata;
                CFG_STATUS_BAD_SECTOR:   stat_badsec_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the exchange state on each transaction; otherwise fold the
    // pending sector byte into the checksum as stage two moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_NONE;
            sec_hi_reg <= 8'h00;
            sec_lo_reg <= 8'h00;
            idx_reg   <= '0;
            chk_reg   <= 8'h00;
            rchk_reg  <= 8'h00;
            ffb_reg   <= 1'b0;
            flag_reg  <= FLAG_NEW;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            sec_hi_reg <= sec_hi_next;
            sec_lo_reg <= sec_lo_next;
            idx_reg    <= idx_next;
            chk_reg    <= chk_next;
            rchk_reg   <= rchk_next;
            ffb_reg    <= ffb_next;
            flag_reg   <= flag_next;
        end else if (s2_advance && s2_mem_reg) begin
            chk_reg <= chk_reg ^ rd_data_reg;
        end
    end

    // Clearing pass after reset: one store entry a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}}) clr_active_reg <= 1'b0;
        end
    end

    assign mem_we    = clr_active_reg || (accept && wr_en_c);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr_c;
    assign mem_wdata = clr_active_reg ? 8'h00 : b;

    // Sector store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) card_mem[mem_waddr] <= mem_wdata;
        if (accept && rd_en_c) rd_data_reg <= card_mem[rd_addr_c];
    end

    // Stage two holds the decoded reply until the output register frees up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (accept) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_advance) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_mem_reg   <= use_mem_c;
            s2_reply_reg <= reply_c;
            s2_ack_reg   <= !s_data.deselect && !go_idle;
            s2_done_reg  <= !s_data.deselect && done_c;
        end
    end

    // Output register parts the result side from the input side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_advance) begin
            m_data_reg.reply_byte    <= s2_mem_reg ? rd_data_reg : s2_reply_reg;
            m_data_reg.acknowledge   <= s2_ack_reg;
            m_data_reg.exchange_done <= s2_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // No transaction enters while the store is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("transaction accepted during store clearing pass");

    // A stalled stage two keeps its result.
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !out_free) |=> (s2_valid_reg && $stable(rd_data_reg)))
        else $error("stage two result lost while stalled");

    // The store is never read and written by the same transaction.
    a_no_rw_same: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(rd_en_c && wr_en_c))
        else $error("store read and write in one transaction");

    // A completed exchange never acknowledges its final byte.
    a_done_no_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.exchange_done) |-> !m_data_reg.acknowledge)
        else $error("exchange done with acknowledge set");

endmodule
